// File: rtl/rpab_pkg.sv
// Shared types and constants for the RGBA alpha blend unit.
package rpab_pkg;

    localparam int unsigned CHAN_W = 8;
    localparam int unsigned NUM_COLOURS = 3;
    localparam logic [CHAN_W-1:0] FULL = 8'd255;

    // Width of the colour numerator: at most 255^3, so 24 bits.
    localparam int unsigned NUM_W = 24;

    // Exact reciprocals: floor(n / 65025) = (n * RECIP_C) >> RECIP_C_SH for n < 2^24,
    // floor(x / 255) = (x * RECIP_A) >> RECIP_A_SH for x < 2^16.
    localparam int unsigned RECIP_C_W = 25;
    localparam logic [RECIP_C_W-1:0] RECIP_C = 25'd16909061;
    localparam int unsigned RECIP_C_SH = 40;
    localparam int unsigned RECIP_A_W = 17;
    localparam logic [RECIP_A_W-1:0] RECIP_A = 17'd65794;
    localparam int unsigned RECIP_A_SH = 24;

    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned CFG_DATA_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_ENABLE        = 8'd0,
        CFG_KEY_ALPHA         = 8'd1,
        CFG_EQUAL_ALPHA_BLEND = 8'd2,
        CFG_INVERT_ALPHA_OUT  = 8'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [CHAN_W-1:0] dst_red;
        logic [CHAN_W-1:0] dst_green;
        logic [CHAN_W-1:0] dst_blue;
        logic [CHAN_W-1:0] dst_alpha;
        logic [CHAN_W-1:0] src_red;
        logic [CHAN_W-1:0] src_green;
        logic [CHAN_W-1:0] src_blue;
        logic [CHAN_W-1:0] src_alpha;
    } t_pix_in;

    typedef struct packed {
        logic [CHAN_W-1:0] out_red;
        logic [CHAN_W-1:0] out_green;
        logic [CHAN_W-1:0] out_blue;
        logic [CHAN_W-1:0] out_alpha;
    } t_pix_out;

endpackage

// File: rtl/rgba_pixel_alpha_blend_unit.sv
// Pipelined RGBA "over" compositing unit with key and equal-alpha modes.
// Throughput: one beat per cycle; o_busy stays low, as the four register stages never stall.
// The depth is set by the colour path: product, weighted sum, reciprocal multiply, select.
// The receiver cannot hold results off, so every result is shown for exactly one cycle.
// Reset (synchronous, active low) clears the stage valid bits and the configuration registers.
module rgba_pixel_alpha_blend_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    output logic                                  o_busy,
    input  rpab_pkg::t_pix_in                     i_pix,
    output logic                                  o_valid,
    output rpab_pkg::t_pix_out                    o_pix,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [rpab_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [rpab_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    localparam int unsigned W  = rpab_pkg::CHAN_W;
    localparam int unsigned NC = rpab_pkg::NUM_COLOURS;
    localparam int unsigned NW = rpab_pkg::NUM_W;

    typedef enum logic [1:0] {
        MODE_BLEND = 2'd0,
        MODE_KEY   = 2'd1,
        MODE_EQUAL = 2'd2
    } t_mode;

    // Configuration registers.
    logic         r_key_enable;
    logic [W-1:0] r_key_alpha;
    logic         r_equal_blend;
    logic         r_invert;

    assign o_cfg_ready = 1'b1;
    assign o_busy      = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_enable  <= 1'b0;
            r_key_alpha   <= '0;
            r_equal_blend <= 1'b0;
            r_invert      <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                rpab_pkg::CFG_KEY_ENABLE:        r_key_enable  <= i_cfg_data[0];
                rpab_pkg::CFG_KEY_ALPHA:         r_key_alpha   <= i_cfg_data[W-1:0];
                rpab_pkg::CFG_EQUAL_ALPHA_BLEND: r_equal_blend <= i_cfg_data[0];
                rpab_pkg::CFG_INVERT_ALPHA_OUT:  r_invert      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Unpack the beat into per-channel arrays.
    logic [W-1:0] dst_c [NC];
    logic [W-1:0] src_c [NC];
    logic [W-1:0] td;
    logic [W-1:0] ts;
    logic         accept;
    t_mode        mode_in;

    always_comb begin
        dst_c[0] = i_pix.dst_red;
        dst_c[1] = i_pix.dst_green;
        dst_c[2] = i_pix.dst_blue;
        src_c[0] = i_pix.src_red;
        src_c[1] = i_pix.src_green;
        src_c[2] = i_pix.src_blue;
        td       = i_pix.dst_alpha;
        ts       = i_pix.src_alpha;
        accept   = i_start && !o_busy;
        if (r_key_enable && (ts == r_key_alpha)) begin
            mode_in = MODE_KEY;
        end else if (!r_equal_blend && (td == ts)) begin
            mode_in = MODE_EQUAL;
        end else begin
            mode_in = MODE_BLEND;
        end
    end

    // Stage 1: destination products td*cd and source weight ts*(255-td).
    logic             r1_valid;
    t_mode            r1_mode;
    logic [W-1:0]     r1_pass [NC];
    logic [W-1:0]     r1_cs   [NC];
    logic [2*W-1:0]   r1_dprod [NC];
    logic [2*W-1:0]   r1_sw;
    logic [W-1:0]     r1_td;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_mode <= mode_in;
        r1_td   <= td;
        r1_sw   <= ts * (rpab_pkg::FULL - td);
        for (int i = 0; i < NC; i++) begin
            r1_pass[i]  <= (mode_in == MODE_KEY) ? src_c[i] : dst_c[i];
            r1_cs[i]    <= src_c[i];
            r1_dprod[i] <= dst_c[i] * td;
        end
    end

    // Stage 2: colour numerator and the alpha quotient by 255.
    logic                          r2_valid;
    t_mode                         r2_mode;
    logic [W-1:0]                  r2_pass [NC];
    logic [NW-1:0]                 r2_num  [NC];
    logic [W-1:0]                  r2_td;
    logic [W-1:0]                  r2_aq;
    logic [2*W+rpab_pkg::RECIP_A_W-1:0] n_aprod;
    logic [NW-1:0]                 n_num [NC];

    always_comb begin
        n_aprod = r1_sw * rpab_pkg::RECIP_A;
        for (int i = 0; i < NC; i++) begin
            // td*cd*255 as a shift and subtract.
            n_num[i] = ({r1_dprod[i], {W{1'b0}}} - {{W{1'b0}}, r1_dprod[i]})
                     + (NW'(r1_sw) * NW'(r1_cs[i]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_mode <= r1_mode;
        r2_td   <= r1_td;
        r2_aq   <= n_aprod[rpab_pkg::RECIP_A_SH +: W];
        for (int i = 0; i < NC; i++) begin
            r2_pass[i] <= r1_pass[i];
            r2_num[i]  <= n_num[i];
        end
    end

    // Stage 3: colour quotient by 65025 and the combined alpha.
    logic                                r3_valid;
    t_mode                               r3_mode;
    logic [W-1:0]                        r3_pass [NC];
    logic [W-1:0]                        r3_col  [NC];
    logic [W-1:0]                        r3_t;
    logic [NW+rpab_pkg::RECIP_C_W-1:0]   n_cprod [NC];

    always_comb begin
        for (int i = 0; i < NC; i++) begin
            n_cprod[i] = r2_num[i] * rpab_pkg::RECIP_C;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_mode <= r2_mode;
        // The sum never exceeds 255.
        r3_t    <= r2_td + r2_aq;
        for (int i = 0; i < NC; i++) begin
            r3_pass[i] <= r2_pass[i];
            r3_col[i]  <= n_cprod[i][rpab_pkg::RECIP_C_SH +: W];
        end
    end

    // Stage 4: mode select, alpha inversion and the output register.
    logic               r_valid;
    rpab_pkg::t_pix_out r_pix;
    logic [W-1:0]       n_col [NC];
    logic [W-1:0]       n_t;
    logic [W-1:0]       n_alpha;

    always_comb begin
        if (r3_mode == MODE_BLEND) begin
            n_t = r3_t;
            for (int i = 0; i < NC; i++) begin
                n_col[i] = r3_col[i];
            end
        end else begin
            n_t = rpab_pkg::FULL;
            for (int i = 0; i < NC; i++) begin
                n_col[i] = r3_pass[i];
            end
        end
        n_alpha = r_invert ? (rpab_pkg::FULL - n_t) : n_t;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pix.out_red   <= n_col[0];
        r_pix.out_green <= n_col[1];
        r_pix.out_blue  <= n_col[2];
        r_pix.out_alpha <= n_alpha;
    end

    assign o_valid = r_valid;
    assign o_pix   = r_pix;

endmodule

// File: rtl/rpab_checker.sv
// Port-level checker for the RGBA alpha blend unit, bound to the top level.
module rpab_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_start,
    input logic                 o_busy,
    input rpab_pkg::t_pix_in    i_pix,
    input logic                 o_valid,
    input rpab_pkg::t_pix_out   o_pix
);

    // A result beat always comes from a matching start.
    a_valid_from_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start && !o_busy, 4))
        else $error("result beat without a matching start");

    // A start taken outside reset always yields its result beat.
    a_start_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && $past(i_rst_n, 1) && i_rst_n) |=> ##3 (o_valid || !$past(i_rst_n, 3)
        || !$past(i_rst_n, 2) || !$past(i_rst_n, 1)))
        else $error("start beat lost in the pipeline");

    // The combined alpha never falls below the destination alpha, in either convention.
    a_alpha_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_pix.out_alpha >= $past(i_pix.dst_alpha, 4))
        || (o_pix.out_alpha <= (rpab_pkg::FULL - $past(i_pix.dst_alpha, 4)))))
        else $error("output alpha below destination alpha");

    // The red result is a sum of the inputs with weights totalling at most 65025, so it never exceeds the larger input.
    a_red_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_pix.out_red <= $past(i_pix.dst_red, 4))
        || (o_pix.out_red <= $past(i_pix.src_red, 4))))
        else $error("red channel above both inputs");

endmodule

bind rgba_pixel_alpha_blend_unit rpab_checker u_rpab_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (i_start),
    .o_busy  (o_busy),
    .i_pix   (i_pix),
    .o_valid (o_valid),
    .o_pix   (o_pix)
);
